// ===== src/scsl_pkg.sv =====
// Shared types, sizes and op codes for the shortest common supersequence engine.
// No dependencies.
package scsl_pkg;

  localparam int MAX_LEN = 64;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LEN_W   = $clog2(2 * MAX_LEN + 1);
  localparam int OP_W    = 2;
  localparam int SYM_W   = 8;
  localparam int OUT_W   = 8;

  typedef logic [OP_W-1:0]  op_t;
  typedef logic [SYM_W-1:0] sym_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [LEN_W-1:0] len_t;
  typedef logic [OUT_W-1:0] out_len_t;

  localparam op_t OP_LOAD_FIRST  = 2'd0;
  localparam op_t OP_LOAD_SECOND = 2'd1;
  localparam op_t OP_COMPUTE     = 2'd2;

  function automatic out_len_t sat_len(input len_t v);
    logic [31:0] wide;
    begin
      wide = 32'(v);
      if (wide > 32'(2**OUT_W - 1)) begin
        sat_len = {OUT_W{1'b1}};
      end else begin
        sat_len = OUT_W'(wide);
      end
    end
  endfunction

endpackage

// ===== src/scsl_if.sv =====
// Valid/ready channel interfaces for the input ops and the length results.
// Depends on scsl_pkg.
interface scsl_in_if import scsl_pkg::*; ();
  logic valid;
  logic ready;
  op_t  op;
  sym_t symbol;
  modport source (output valid, op, symbol, input ready);
  modport sink   (input valid, op, symbol, output ready);
endinterface

interface scsl_out_if import scsl_pkg::*; ();
  logic     valid;
  logic     ready;
  out_len_t super_length;
  logic     overflowed;
  modport source (output valid, super_length, overflowed, input ready);
  modport sink   (input valid, super_length, overflowed, output ready);
endinterface

// ===== src/scsl_cell.sv =====
// Shared table cell unit: one symbol compare, one min, one increment.
// Depends on scsl_pkg.
module scsl_cell import scsl_pkg::*; (
  input  sym_t a_sym,
  input  sym_t b_sym,
  input  len_t up,
  input  len_t left,
  input  len_t diag,
  output len_t cell_len
);
  len_t base;

  always_comb begin
    if (a_sym == b_sym) begin
      base = diag;
    end else if (up < left) begin
      base = up;
    end else begin
      base = left;
    end
    cell_len = base + LEN_W'(1);
  end
endmodule

// ===== src/shortest_common_supersequence_length.sv =====
// Shortest common supersequence length engine, top level. Depends on scsl_pkg,
// scsl_if and scsl_cell.
// Loads (ops 0, 1) append one symbol each. For nonempty strings, compute runs the table
// row by row (one cell per cycle, a drain state after each row), then registers the result;
// with an empty string it emits the summed length without a pass. Not ready meanwhile.
// Synchronous active-low reset clears counts, overflow flag and control; no clear pass.
module shortest_common_supersequence_length import scsl_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  scsl_in_if.sink      in_ch,
  scsl_out_if.source   out_ch
);
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0] state_r, state_nxt;
  cnt_t       n1_r, n1_nxt;
  cnt_t       n2_r, n2_nxt;
  logic       ovf_r, ovf_nxt;
  cnt_t       row_r, row_nxt;
  idx_t       col_r, col_nxt;
  logic       p_valid_r, p_valid_nxt;
  idx_t       p_col_r;
  logic       p_first_r;
  len_t       left_r, left_nxt;
  len_t       diag_r, diag_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_len_t   out_len_r, out_len_nxt;
  logic       out_ovf_r, out_ovf_nxt;

  sym_t first_mem  [MAX_LEN];
  sym_t second_mem [MAX_LEN];
  len_t table_mem  [MAX_LEN];
  sym_t a_q, b_q;
  len_t up_q;

  logic   xfer_in;
  logic   wr_first, wr_second;
  idx_t   a_raddr;
  len_t   up_v, left_v, diag_v, cell_len;

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign xfer_in             = in_ch.valid && in_ch.ready;
  assign wr_first            = xfer_in && (in_ch.op == OP_LOAD_FIRST) && (n1_r != CNT_W'(MAX_LEN));
  assign wr_second           = xfer_in && (in_ch.op == OP_LOAD_SECOND) && (n2_r != CNT_W'(MAX_LEN));
  assign a_raddr             = IDX_W'(row_r - CNT_W'(1));
  assign out_ch.valid        = out_valid_r;
  assign out_ch.super_length = out_len_r;
  assign out_ch.overflowed   = out_ovf_r;

  always_ff @(posedge clk) begin
    if (wr_first) begin
      first_mem[n1_r[IDX_W-1:0]] <= in_ch.symbol;
    end
    a_q <= first_mem[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr_second) begin
      second_mem[n2_r[IDX_W-1:0]] <= in_ch.symbol;
    end
    b_q <= second_mem[col_r];
  end

  always_ff @(posedge clk) begin
    if (p_valid_r) begin
      table_mem[p_col_r] <= cell_len;
    end
    up_q <= table_mem[col_r];
  end

  // cell stage operands
  always_comb begin
    up_v   = (row_r == CNT_W'(1)) ? (LEN_W'(p_col_r) + LEN_W'(1)) : up_q;
    left_v = p_first_r ? LEN_W'(row_r) : left_r;
    diag_v = p_first_r ? LEN_W'(row_r - CNT_W'(1)) : diag_r;
  end

  scsl_cell u_cell (
    .a_sym    (a_q),
    .b_sym    (b_q),
    .up       (up_v),
    .left     (left_v),
    .diag     (diag_v),
    .cell_len (cell_len)
  );

  always_comb begin
    state_nxt     = state_r;
    n1_nxt        = n1_r;
    n2_nxt        = n2_r;
    ovf_nxt       = ovf_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    p_valid_nxt   = 1'b0;
    left_nxt      = left_r;
    diag_nxt      = diag_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_len_nxt   = out_len_r;
    out_ovf_nxt   = out_ovf_r;

    if (p_valid_r) begin
      left_nxt = cell_len;
      diag_nxt = up_v;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (xfer_in) begin
          case (in_ch.op)
            OP_LOAD_FIRST: begin
              if (wr_first) begin
                n1_nxt = n1_r + CNT_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            OP_LOAD_SECOND: begin
              if (wr_second) begin
                n2_nxt = n2_r + CNT_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            OP_COMPUTE: begin
              if ((n1_r == '0) || (n2_r == '0)) begin
                left_nxt  = LEN_W'(n1_r) + LEN_W'(n2_r);
                state_nxt = ST_EMIT;
              end else begin
                row_nxt   = CNT_W'(1);
                col_nxt   = '0;
                state_nxt = ST_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        p_valid_nxt = 1'b1;
        if ((CNT_W'(col_r) + CNT_W'(1)) == n2_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          col_nxt = col_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (row_r == n1_r) begin
          state_nxt = ST_EMIT;
        end else begin
          row_nxt   = row_r + CNT_W'(1);
          col_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_len_nxt   = sat_len(left_r);
          out_ovf_nxt   = ovf_r;
          n1_nxt        = '0;
          n2_nxt        = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      n1_r        <= '0;
      n2_r        <= '0;
      ovf_r       <= 1'b0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      row_r       <= '0;
      col_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      n1_r        <= n1_nxt;
      n2_r        <= n2_nxt;
      ovf_r       <= ovf_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_col_r   <= col_r;
    p_first_r <= (col_r == '0);
    left_r    <= left_nxt;
    diag_r    <= diag_nxt;
    out_len_r <= out_len_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

endmodule
